[rtl/pse_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_pkg
// Shared types, constants and state encodings of the stroke expander.
// ----------------------------------------------------------------------------
package pse_pkg;

    localparam int COORD_BITS_DEFAULT = 24;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [15:0] HALF_THICKNESS_RST = 16'd256;
    localparam logic [7:0]  STROKE_ALPHA_RST   = 8'd255;

    typedef enum logic {
        REG_HALF_THICKNESS = 1'b0,
        REG_STROKE_ALPHA   = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] half_thickness;
        logic [7:0]  stroke_alpha;
    } cfg_t;

    // offset arithmetic
    localparam int NORM_TOP   = 30;   // normalized magnitude lies in [2^30, 2^31)
    localparam int NORM_STEPS = 5;    // left shifts by 16, 8, 4, 2, 1
    localparam int SQRT_STEPS = 32;
    localparam int QUO_W      = 17;
    localparam int DIV_STEPS  = QUO_W;
    localparam int OFF_W      = QUO_W + 1;
    localparam int ALU_W      = 64;

    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef enum logic [3:0] {
        OFF_IDLE,
        OFF_NORM_R,
        OFF_NORM_L,
        OFF_SQ_X,
        OFF_SQ_Y,
        OFF_SUM,
        OFF_SQRT,
        OFF_MUL_H,
        OFF_NUM,
        OFF_DIV,
        OFF_DONE
    } off_state_t;

    typedef struct packed {
        logic                    done;
        logic signed [OFF_W-1:0] ox;
        logic signed [OFF_W-1:0] oy;
    } off_result_t;

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_LAUNCH,
        CTL_WAIT,
        CTL_EMIT
    } ctl_state_t;

endpackage

[rtl/pse_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_if
// Stream interfaces for polyline points and stroke quads.
// ----------------------------------------------------------------------------
interface pse_point_if import pse_pkg::*; #(
    parameter int CoordBits = COORD_BITS_DEFAULT
) ();
    logic                        valid;
    logic                        ready;
    logic signed [CoordBits-1:0] point_x;
    logic signed [CoordBits-1:0] point_y;
    logic                        is_first;
    logic                        is_last;
    logic                        closed;

    modport source (
        output valid, point_x, point_y, is_first, is_last, closed,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, is_first, is_last, closed,
        output ready
    );
endinterface

interface pse_quad_if import pse_pkg::*; #(
    parameter int CoordBits = COORD_BITS_DEFAULT
) ();
    logic                        valid;
    logic                        ready;
    logic signed [CoordBits-1:0] corner0_x;
    logic signed [CoordBits-1:0] corner0_y;
    logic signed [CoordBits-1:0] corner1_x;
    logic signed [CoordBits-1:0] corner1_y;
    logic signed [CoordBits-1:0] corner2_x;
    logic signed [CoordBits-1:0] corner2_y;
    logic signed [CoordBits-1:0] corner3_x;
    logic signed [CoordBits-1:0] corner3_y;
    logic [31:0]                 base_index;
    logic                        last_of_run;

    modport source (
        output valid, corner0_x, corner0_y, corner1_x, corner1_y,
               corner2_x, corner2_y, corner3_x, corner3_y, base_index, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, corner0_x, corner0_y, corner1_x, corner1_y,
               corner2_x, corner2_y, corner3_x, corner3_y, base_index, last_of_run,
        output ready
    );
endinterface

[rtl/polyline_stroke_expander_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_stroke_expander_unit
// Turns a stream of polyline points into stroke quads with running indices.
//
// Points arrive on the pnt channel, quads leave on the quad channel, both
// valid/ready. The APB port sets half_thickness (0x0) and stroke_alpha (0x4).
// A point that opens a line, or any point while alpha is zero, is only
// stored. A point that closes a segment launches the offset sequencer: the
// quad is valid after the launch, the sequencer steps dominated by the
// 32-step square root and the two 17-step restoring divisions on the shared
// multiply/add unit, and the emit step; a zero-length segment gets a zero
// offset without the arithmetic. The last point of a closed line produces a
// second quad for the closing segment. With 32-bit coordinates a long
// segment is first shifted right in the normalize step.
// pnt.ready is high only while the sequencer is idle. A finished quad sits
// in the output register; the next point is accepted while it waits, and a
// new quad holds in the emit step until the receiver takes the old one.
// Reset clears the line state, the vertex counter and both registers to
// their defaults (half_thickness 1.0 pixel, alpha 255).
// ----------------------------------------------------------------------------
module polyline_stroke_expander_unit import pse_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    pse_point_if.sink             pnt,
    pse_quad_if.source            quad,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int SumW = ((COORD_BITS > OFF_W) ? COORD_BITS : OFF_W) + 1;
    localparam logic signed [SumW-1:0] SatHi =
        SumW'((longint'(1) <<< (COORD_BITS - 1)) - longint'(1));
    localparam logic signed [SumW-1:0] SatLo = ~SatHi;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    cfg_t        cfg;
    off_result_t off_res;
    logic        off_start;

    ctl_state_t  st_reg, st_next;
    coord_t      prev_x_reg, prev_x_next;
    coord_t      prev_y_reg, prev_y_next;
    coord_t      start_x_reg, start_x_next;
    coord_t      start_y_reg, start_y_next;
    logic        have_point_reg, have_point_next;
    logic [31:0] vcnt_reg, vcnt_next;
    coord_t      seg_ax_reg, seg_ax_next;
    coord_t      seg_ay_reg, seg_ay_next;
    coord_t      seg_bx_reg, seg_bx_next;
    coord_t      seg_by_reg, seg_by_next;
    logic        close_pend_reg, close_pend_next;
    logic        seg_last_reg, seg_last_next;
    logic        qv_reg, qv_next;
    coord_t      corner_reg [8];
    coord_t      corner_next [8];
    logic [31:0] base_reg, base_next;
    logic        lor_reg, lor_next;

    logic        pnt_acc;
    logic        emit_ok;
    logic signed [COORD_BITS:0] seg_dx;
    logic signed [COORD_BITS:0] seg_dy;
    coord_t      calc [8];

    function automatic coord_t sat_add(input coord_t p, input logic signed [OFF_W-1:0] o,
                                       input logic neg);
        logic signed [SumW-1:0] s;
        coord_t                 r;
        s = neg ? SumW'(p) - SumW'(o) : SumW'(p) + SumW'(o);
        if (s > SatHi)
        begin
            r = SatHi[COORD_BITS-1:0];
        end
        else if (s < SatLo)
        begin
            r = SatLo[COORD_BITS-1:0];
        end
        else
        begin
            r = s[COORD_BITS-1:0];
        end
        return r;
    endfunction

    pse_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign seg_dx    = (COORD_BITS+1)'(seg_bx_reg) - (COORD_BITS+1)'(seg_ax_reg);
    assign seg_dy    = (COORD_BITS+1)'(seg_by_reg) - (COORD_BITS+1)'(seg_ay_reg);
    assign off_start = (st_reg == CTL_LAUNCH);

    pse_offset_unit #(
        .CoordBits (COORD_BITS)
    ) u_offset (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (off_start),
        .dx             (seg_dx),
        .dy             (seg_dy),
        .half_thickness (cfg.half_thickness),
        .res            (off_res)
    );

    assign calc[0] = sat_add(seg_ax_reg, off_res.oy, 1'b0);
    assign calc[1] = sat_add(seg_ay_reg, off_res.ox, 1'b1);
    assign calc[2] = sat_add(seg_bx_reg, off_res.oy, 1'b0);
    assign calc[3] = sat_add(seg_by_reg, off_res.ox, 1'b1);
    assign calc[4] = sat_add(seg_bx_reg, off_res.oy, 1'b1);
    assign calc[5] = sat_add(seg_by_reg, off_res.ox, 1'b0);
    assign calc[6] = sat_add(seg_ax_reg, off_res.oy, 1'b1);
    assign calc[7] = sat_add(seg_ay_reg, off_res.ox, 1'b0);

    assign pnt.ready = (st_reg == CTL_IDLE);
    assign pnt_acc   = pnt.valid && pnt.ready;
    assign emit_ok   = (st_reg == CTL_EMIT) && (!qv_reg || quad.ready);

    always_comb
    begin
        st_next         = st_reg;
        prev_x_next     = prev_x_reg;
        prev_y_next     = prev_y_reg;
        start_x_next    = start_x_reg;
        start_y_next    = start_y_reg;
        have_point_next = have_point_reg;
        vcnt_next       = vcnt_reg;
        seg_ax_next     = seg_ax_reg;
        seg_ay_next     = seg_ay_reg;
        seg_bx_next     = seg_bx_reg;
        seg_by_next     = seg_by_reg;
        close_pend_next = close_pend_reg;
        seg_last_next   = seg_last_reg;
        corner_next     = corner_reg;
        base_next       = base_reg;
        lor_next        = lor_reg;
        qv_next         = (qv_reg && !quad.ready) || emit_ok;

        unique case (st_reg)
            CTL_IDLE:
            begin
                if (pnt_acc)
                begin
                    if (pnt.is_first || !have_point_reg)
                    begin
                        start_x_next = pnt.point_x;
                        start_y_next = pnt.point_y;
                    end
                    else if (cfg.stroke_alpha != '0)
                    begin
                        seg_ax_next     = prev_x_reg;
                        seg_ay_next     = prev_y_reg;
                        seg_bx_next     = pnt.point_x;
                        seg_by_next     = pnt.point_y;
                        close_pend_next = pnt.is_last && pnt.closed;
                        seg_last_next   = !(pnt.is_last && pnt.closed);
                        st_next         = CTL_LAUNCH;
                    end
                    prev_x_next     = pnt.point_x;
                    prev_y_next     = pnt.point_y;
                    have_point_next = !pnt.is_last;
                end
            end
            CTL_LAUNCH:
            begin
                st_next = CTL_WAIT;
            end
            CTL_WAIT:
            begin
                if (off_res.done)
                begin
                    st_next = CTL_EMIT;
                end
            end
            CTL_EMIT:
            begin
                if (emit_ok)
                begin
                    corner_next = calc;
                    base_next   = vcnt_reg;
                    lor_next    = seg_last_reg;
                    vcnt_next   = vcnt_reg + 32'd4;
                    if (close_pend_reg)
                    begin
                        seg_ax_next     = seg_bx_reg;
                        seg_ay_next     = seg_by_reg;
                        seg_bx_next     = start_x_reg;
                        seg_by_next     = start_y_reg;
                        close_pend_next = 1'b0;
                        seg_last_next   = 1'b1;
                        st_next         = CTL_LAUNCH;
                    end
                    else
                    begin
                        st_next = CTL_IDLE;
                    end
                end
            end
            default:
            begin
                st_next = CTL_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= CTL_IDLE;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            start_x_reg    <= '0;
            start_y_reg    <= '0;
            have_point_reg <= 1'b0;
            vcnt_reg       <= '0;
            close_pend_reg <= 1'b0;
            seg_last_reg   <= 1'b0;
            qv_reg         <= 1'b0;
        end
        else
        begin
            st_reg         <= st_next;
            prev_x_reg     <= prev_x_next;
            prev_y_reg     <= prev_y_next;
            start_x_reg    <= start_x_next;
            start_y_reg    <= start_y_next;
            have_point_reg <= have_point_next;
            vcnt_reg       <= vcnt_next;
            close_pend_reg <= close_pend_next;
            seg_last_reg   <= seg_last_next;
            qv_reg         <= qv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seg_ax_reg <= seg_ax_next;
        seg_ay_reg <= seg_ay_next;
        seg_bx_reg <= seg_bx_next;
        seg_by_reg <= seg_by_next;
        corner_reg <= corner_next;
        base_reg   <= base_next;
        lor_reg    <= lor_next;
    end

    assign quad.valid       = qv_reg;
    assign quad.corner0_x   = corner_reg[0];
    assign quad.corner0_y   = corner_reg[1];
    assign quad.corner1_x   = corner_reg[2];
    assign quad.corner1_y   = corner_reg[3];
    assign quad.corner2_x   = corner_reg[4];
    assign quad.corner2_y   = corner_reg[5];
    assign quad.corner3_x   = corner_reg[6];
    assign quad.corner3_y   = corner_reg[7];
    assign quad.base_index  = base_reg;
    assign quad.last_of_run = lor_reg;

    a_vcnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        emit_ok |=> (vcnt_reg == $past(vcnt_reg) + 32'd4) && (base_reg == $past(vcnt_reg)))
        else $error("vertex counter did not advance by one quad");

    a_close_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_ok && !seg_last_reg) |=> st_reg == CTL_LAUNCH)
        else $error("closing segment not launched after non-final quad");

    a_alpha_mute: assert property (@(posedge clk) disable iff (!rst_n)
        (pnt_acc && cfg.stroke_alpha == '0) |=> st_reg == CTL_IDLE)
        else $error("segment launched with zero alpha");

endmodule

[rtl/pse_apb_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_apb_regs
// APB register file: half stroke thickness and stroke alpha.
// ----------------------------------------------------------------------------
module pse_apb_regs import pse_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [15:0] half_thickness_reg;
    logic [15:0] half_thickness_next;
    logic [7:0]  stroke_alpha_reg;
    logic [7:0]  stroke_alpha_next;
    logic        wr_en;
    reg_idx_t    idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[2]);

    always_comb
    begin
        half_thickness_next = half_thickness_reg;
        stroke_alpha_next   = stroke_alpha_reg;
        prdata              = '0;
        unique case (idx)
            REG_HALF_THICKNESS:
            begin
                prdata = APB_DATA_W'(half_thickness_reg);
                if (wr_en)
                begin
                    half_thickness_next = pwdata[15:0];
                end
            end
            REG_STROKE_ALPHA:
            begin
                prdata = APB_DATA_W'(stroke_alpha_reg);
                if (wr_en)
                begin
                    stroke_alpha_next = pwdata[7:0];
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_thickness_reg <= HALF_THICKNESS_RST;
            stroke_alpha_reg   <= STROKE_ALPHA_RST;
        end
        else
        begin
            half_thickness_reg <= half_thickness_next;
            stroke_alpha_reg   <= stroke_alpha_next;
        end
    end

    assign cfg.half_thickness = half_thickness_reg;
    assign cfg.stroke_alpha   = stroke_alpha_reg;

endmodule

[rtl/pse_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_alu
// Shared arithmetic unit: 32x32 multiply, 64-bit add and subtract/compare.
// ----------------------------------------------------------------------------
module pse_alu import pse_pkg::*; (
    input  alu_op_t          op,
    input  logic [ALU_W-1:0] a,
    input  logic [ALU_W-1:0] b,
    output logic [ALU_W-1:0] res,
    output logic             ge
);

    logic [ALU_W:0] diff;

    assign diff = {1'b0, a} - {1'b0, b};
    assign ge   = !diff[ALU_W];

    always_comb
    begin
        unique case (op)
            ALU_MUL: res = ALU_W'(a[31:0] * b[31:0]);
            ALU_ADD: res = a + b;
            ALU_SUB: res = diff[ALU_W-1:0];
            default: res = '0;
        endcase
    end

endmodule

[rtl/pse_offset_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_offset_unit
// Sequenced offset computation: normalize, square, square root, then two
// restoring divisions, all through one shared arithmetic unit.
// ----------------------------------------------------------------------------
module pse_offset_unit import pse_pkg::*; #(
    parameter int CoordBits = COORD_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic signed [CoordBits:0] dx,
    input  logic signed [CoordBits:0] dy,
    input  logic [15:0]           half_thickness,
    output off_result_t           res
);

    localparam int MagW  = CoordBits + 1;
    localparam int WorkW = (MagW > NORM_TOP + 1) ? MagW : NORM_TOP + 1;

    off_state_t       st_reg, st_next;
    logic [WorkW-1:0] mx_reg, mx_next;
    logic [WorkW-1:0] my_reg, my_next;
    logic             sgnx_reg, sgnx_next;
    logic             sgny_reg, sgny_next;
    logic             pass_y_reg, pass_y_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic [ALU_W-1:0] acc_reg, acc_next;
    logic [ALU_W-1:0] prod_reg, prod_next;
    logic [ALU_W-1:0] root_reg, root_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [QUO_W-1:0] qx_reg, qx_next;
    logic [QUO_W-1:0] qy_reg, qy_next;

    logic [MagW-1:0]  mag_x;
    logic [MagW-1:0]  mag_y;
    logic [WorkW-1:0] m_w;
    logic [4:0]       k_amt;
    logic             shl_ok;
    logic [ALU_W-1:0] sq_bit;
    logic [ALU_W-1:0] div_sub;
    alu_op_t          alu_op;
    logic [ALU_W-1:0] alu_a;
    logic [ALU_W-1:0] alu_b;
    logic [ALU_W-1:0] alu_res;
    logic             alu_ge;

    assign mag_x   = dx[CoordBits] ? unsigned'(-dx) : unsigned'(dx);
    assign mag_y   = dy[CoordBits] ? unsigned'(-dy) : unsigned'(dy);
    assign m_w     = (mx_reg > my_reg) ? mx_reg : my_reg;
    assign k_amt   = 5'd16 >> cnt_reg[2:0];
    assign shl_ok  = (m_w >> (NORM_TOP + 1 - int'(k_amt))) == '0;
    assign sq_bit  = ALU_W'(1) << (6'd62 - {cnt_reg[4:0], 1'b0});
    assign div_sub = ALU_W'({root_reg[31:0], 1'b0}) << (5'd16 - cnt_reg[4:0]);

    pse_alu u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res),
        .ge  (alu_ge)
    );

    always_comb
    begin
        alu_op = ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
        unique case (st_reg)
            OFF_SQ_X:
            begin
                alu_op = ALU_MUL;
                alu_a  = ALU_W'(mx_reg);
                alu_b  = ALU_W'(mx_reg);
            end
            OFF_SQ_Y:
            begin
                alu_op = ALU_MUL;
                alu_a  = ALU_W'(my_reg);
                alu_b  = ALU_W'(my_reg);
            end
            OFF_SUM:
            begin
                alu_a = acc_reg;
                alu_b = prod_reg;
            end
            OFF_SQRT:
            begin
                alu_op = ALU_SUB;
                alu_a  = acc_reg;
                alu_b  = root_reg | sq_bit;
            end
            OFF_MUL_H:
            begin
                alu_op = ALU_MUL;
                alu_a  = pass_y_reg ? ALU_W'(my_reg) : ALU_W'(mx_reg);
                alu_b  = ALU_W'(half_thickness);
            end
            OFF_NUM:
            begin
                alu_a = prod_reg << 1;
                alu_b = ALU_W'(root_reg[31:0]);
            end
            OFF_DIV:
            begin
                alu_op = ALU_SUB;
                alu_a  = acc_reg;
                alu_b  = div_sub;
            end
            default:
            begin
                alu_op = ALU_ADD;
            end
        endcase
    end

    always_comb
    begin
        st_next     = st_reg;
        mx_next     = mx_reg;
        my_next     = my_reg;
        sgnx_next   = sgnx_reg;
        sgny_next   = sgny_reg;
        pass_y_next = pass_y_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        prod_next   = prod_reg;
        root_next   = root_reg;
        quo_next    = quo_reg;
        qx_next     = qx_reg;
        qy_next     = qy_reg;
        unique case (st_reg)
            OFF_IDLE:
            begin
                if (start)
                begin
                    mx_next   = WorkW'(mag_x);
                    my_next   = WorkW'(mag_y);
                    sgnx_next = dx[CoordBits];
                    sgny_next = dy[CoordBits];
                    st_next   = OFF_NORM_R;
                end
            end
            OFF_NORM_R:
            begin
                if (m_w == '0)
                begin
                    qx_next = '0;
                    qy_next = '0;
                    st_next = OFF_DONE;
                end
                else if ((m_w >> (NORM_TOP + 1)) != '0)
                begin
                    mx_next = mx_reg >> 1;
                    my_next = my_reg >> 1;
                end
                else
                begin
                    cnt_next = '0;
                    st_next  = OFF_NORM_L;
                end
            end
            OFF_NORM_L:
            begin
                if (shl_ok)
                begin
                    mx_next = mx_reg << k_amt;
                    my_next = my_reg << k_amt;
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(NORM_STEPS - 1))
                begin
                    st_next = OFF_SQ_X;
                end
            end
            OFF_SQ_X:
            begin
                acc_next = alu_res;
                st_next  = OFF_SQ_Y;
            end
            OFF_SQ_Y:
            begin
                prod_next = alu_res;
                st_next   = OFF_SUM;
            end
            OFF_SUM:
            begin
                acc_next  = alu_res;
                root_next = '0;
                cnt_next  = '0;
                st_next   = OFF_SQRT;
            end
            OFF_SQRT:
            begin
                if (alu_ge)
                begin
                    acc_next  = alu_res;
                    root_next = (root_reg >> 1) | sq_bit;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(SQRT_STEPS - 1))
                begin
                    pass_y_next = 1'b0;
                    st_next     = OFF_MUL_H;
                end
            end
            OFF_MUL_H:
            begin
                prod_next = alu_res;
                st_next   = OFF_NUM;
            end
            OFF_NUM:
            begin
                acc_next = alu_res;
                cnt_next = '0;
                quo_next = '0;
                st_next  = OFF_DIV;
            end
            OFF_DIV:
            begin
                if (alu_ge)
                begin
                    acc_next = alu_res;
                end
                quo_next = {quo_reg[QUO_W-2:0], alu_ge};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(DIV_STEPS - 1))
                begin
                    if (pass_y_reg)
                    begin
                        qy_next = {quo_reg[QUO_W-2:0], alu_ge};
                        st_next = OFF_DONE;
                    end
                    else
                    begin
                        qx_next     = {quo_reg[QUO_W-2:0], alu_ge};
                        pass_y_next = 1'b1;
                        st_next     = OFF_MUL_H;
                    end
                end
            end
            OFF_DONE:
            begin
                st_next = OFF_IDLE;
            end
            default:
            begin
                st_next = OFF_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= OFF_IDLE;
            cnt_reg    <= '0;
            pass_y_reg <= 1'b0;
        end
        else
        begin
            st_reg     <= st_next;
            cnt_reg    <= cnt_next;
            pass_y_reg <= pass_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mx_reg   <= mx_next;
        my_reg   <= my_next;
        sgnx_reg <= sgnx_next;
        sgny_reg <= sgny_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        root_reg <= root_next;
        quo_reg  <= quo_next;
        qx_reg   <= qx_next;
        qy_reg   <= qy_next;
    end

    assign res.done = (st_reg == OFF_DONE);
    assign res.ox   = sgnx_reg ? -signed'({1'b0, qx_reg}) : signed'({1'b0, qx_reg});
    assign res.oy   = sgny_reg ? -signed'({1'b0, qy_reg}) : signed'({1'b0, qy_reg});

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> st_reg == OFF_IDLE)
        else $error("offset unit started while busy");

    a_offset_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res.done |-> (qx_reg <= {1'b0, half_thickness}) && (qy_reg <= {1'b0, half_thickness}))
        else $error("offset magnitude exceeds half thickness");

    a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == OFF_NORM_L && st_next == OFF_SQ_X)
        |=> (m_w >> NORM_TOP) == WorkW'(1))
        else $error("normalization left magnitude out of range");

endmodule
